// File: design/btxm_pkg.sv
// Shared types and codes for the binary trie min/max xor block.
package btxm_pkg;

    localparam int OP_W  = 2;
    localparam int VAL_W = 31;
    localparam int OUT_W = 31;
    localparam int ST_W  = 2;
    localparam int CNT_W = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [ST_W-1:0] STS_OK        = 2'd0;
    localparam logic [ST_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] STS_FULL      = 2'd2;
    localparam logic [ST_W-1:0] STS_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE,
        ST_QUERY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OUT_W-1:0] max_xor;
        logic [OUT_W-1:0] min_xor;
    } res_t;

endpackage

// File: design/btxm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module btxm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/btxm_seq.sv
// Trie walk sequencer: check, update and dual query walks over the node RAMs.
module btxm_seq #(
    parameter int KEY_BITS  = 31,
    parameter int NODE_POOL = 65536,
    localparam int NODE_W = $clog2(NODE_POOL),
    localparam int WORD_W = 2 * NODE_W + 2 * btxm_pkg::CNT_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [btxm_pkg::OP_W-1:0]   in_op,
    input  logic [btxm_pkg::VAL_W-1:0]  in_value,
    output logic                        mem_we,
    output logic [NODE_W-1:0]           mem_waddr,
    output logic [WORD_W-1:0]           mem_wdata,
    output logic [NODE_W-1:0]           rd_addr_a,
    output logic [NODE_W-1:0]           rd_addr_b,
    input  logic [WORD_W-1:0]           rd_data_a,
    input  logic [WORD_W-1:0]           rd_data_b,
    output logic                        done_valid,
    input  logic                        done_ready,
    output btxm_pkg::res_t              done_res
);

    localparam int CNT_W  = btxm_pkg::CNT_W;
    localparam int LVL_W  = $clog2(KEY_BITS);
    localparam int FREE_W = $clog2(NODE_POOL + 1);
    localparam int SUM_W  = FREE_W + 1;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

    btxm_pkg::state_t state_reg, state_next;
    logic [btxm_pkg::OP_W-1:0] op_reg, op_next;
    logic [btxm_pkg::ST_W-1:0] status_reg, status_next;
    logic [KEY_BITS-1:0]       key_reg, key_next;
    logic [KEY_BITS-1:0]       ksh_reg, ksh_next;
    logic [LVL_W-1:0]          lvl_reg, lvl_next;
    logic [NODE_W-1:0]         node_a_reg, node_a_next;
    logic [NODE_W-1:0]         node_b_reg, node_b_next;
    logic                      fresh_reg, fresh_next;
    logic                      root_init_reg, root_init_next;
    logic [CNT_W-1:0]          root_cnt_reg, root_cnt_next;
    logic [FREE_W-1:0]         free_reg, free_next;
    logic [KEY_BITS-1:0]       res_a_reg, res_a_next;
    logic [KEY_BITS-1:0]       res_b_reg, res_b_next;

    logic [63:0]         val_ext;
    logic [KEY_BITS-1:0] key_in;
    logic                kbit;
    logic                blank_a, blank_b;
    logic [WORD_W-1:0]   word_a, word_b;
    logic [NODE_W-1:0]   a_c0, a_c1, b_c0, b_c1;
    logic [CNT_W-1:0]    a_n0, a_n1, b_n0, b_n1;
    logic [NODE_W-1:0]   a_cs;
    logic [CNT_W-1:0]    a_ns;
    logic                is_ins;
    logic                alloc;
    logic [NODE_W-1:0]   new_idx;
    logic [NODE_W-1:0]   upd_c0, upd_c1, upd_child;
    logic [CNT_W-1:0]    upd_n0, upd_n1;
    logic                overflow;
    logic                pa, pb, use_a, use_b, ba, bb;
    logic [NODE_W-1:0]   nxt_a, nxt_b;
    logic [63:0]         min_ext, max_ext;

    assign val_ext = 64'(in_value);
    assign key_in  = val_ext[KEY_BITS-1:0];
    assign kbit    = ksh_reg[KEY_BITS-1];

    // A fresh node or a root never written reads as an empty node.
    assign blank_a = fresh_reg || (node_a_reg == '0 && !root_init_reg);
    assign blank_b = (node_b_reg == '0) && !root_init_reg;
    assign word_a  = blank_a ? '0 : rd_data_a;
    assign word_b  = blank_b ? '0 : rd_data_b;

    assign a_c0 = word_a[NODE_W-1:0];
    assign a_c1 = word_a[2*NODE_W-1:NODE_W];
    assign a_n0 = word_a[2*NODE_W+CNT_W-1:2*NODE_W];
    assign a_n1 = word_a[WORD_W-1:2*NODE_W+CNT_W];
    assign b_c0 = word_b[NODE_W-1:0];
    assign b_c1 = word_b[2*NODE_W-1:NODE_W];
    assign b_n0 = word_b[2*NODE_W+CNT_W-1:2*NODE_W];
    assign b_n1 = word_b[WORD_W-1:2*NODE_W+CNT_W];

    assign a_cs = kbit ? a_c1 : a_c0;
    assign a_ns = kbit ? a_n1 : a_n0;

    // Node update for insert and delete
    assign is_ins    = (op_reg == btxm_pkg::OP_INSERT);
    assign alloc     = is_ins && (a_cs == '0);
    assign new_idx   = free_reg[NODE_W-1:0];
    assign upd_child = alloc ? new_idx : a_cs;

    always_comb begin
        upd_c0 = a_c0;
        upd_c1 = a_c1;
        upd_n0 = a_n0;
        upd_n1 = a_n1;
        if (kbit) begin
            upd_c1 = upd_child;
            upd_n1 = is_ins ? a_n1 + CNT_W'(1) : a_n1 - CNT_W'(1);
        end else begin
            upd_c0 = upd_child;
            upd_n0 = is_ins ? a_n0 + CNT_W'(1) : a_n0 - CNT_W'(1);
        end
    end

    // Nodes still needed are lvl+1 once a child is missing.
    assign overflow = (SUM_W'(free_reg) + SUM_W'(lvl_reg) + SUM_W'(1)) > SUM_W'(NODE_POOL);

    // Query walkers: prefer the matching (min) or opposite (max) child when usable
    assign pa    = kbit;
    assign pb    = ~kbit;
    assign use_a = pa ? (a_c1 != '0 && a_n1 != '0) : (a_c0 != '0 && a_n0 != '0);
    assign use_b = pb ? (b_c1 != '0 && b_n1 != '0) : (b_c0 != '0 && b_n0 != '0);
    assign ba    = use_a ? pa : ~pa;
    assign bb    = use_b ? pb : ~pb;
    assign nxt_a = ba ? a_c1 : a_c0;
    assign nxt_b = bb ? b_c1 : b_c0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= btxm_pkg::ST_IDLE;
            fresh_reg     <= 1'b0;
            root_init_reg <= 1'b0;
            root_cnt_reg  <= '0;
            free_reg      <= FREE_W'(1);
        end else begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            root_init_reg <= root_init_next;
            root_cnt_reg  <= root_cnt_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        ksh_reg    <= ksh_next;
        lvl_reg    <= lvl_next;
        node_a_reg <= node_a_next;
        node_b_reg <= node_b_next;
        res_a_reg  <= res_a_next;
        res_b_reg  <= res_b_next;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        key_next       = key_reg;
        ksh_next       = ksh_reg;
        lvl_next       = lvl_reg;
        node_a_next    = node_a_reg;
        node_b_next    = node_b_reg;
        fresh_next     = fresh_reg;
        root_cnt_next  = root_cnt_reg;
        free_next      = free_reg;
        res_a_next     = res_a_reg;
        res_b_next     = res_b_reg;
        in_ready       = 1'b0;
        done_valid     = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            btxm_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = in_op;
                    key_next    = key_in;
                    ksh_next    = key_in;
                    lvl_next    = LVL_TOP;
                    node_a_next = '0;
                    node_b_next = '0;
                    fresh_next  = 1'b0;
                    res_a_next  = '0;
                    res_b_next  = '0;
                    status_next = btxm_pkg::STS_OK;
                    case (in_op)
                        btxm_pkg::OP_INSERT: begin
                            if (root_cnt_reg == btxm_pkg::COUNT_MAX) begin
                                status_next = btxm_pkg::STS_FULL;
                                state_next  = btxm_pkg::ST_DONE;
                            end else begin
                                state_next = btxm_pkg::ST_CHECK;
                            end
                        end
                        btxm_pkg::OP_DELETE: begin
                            state_next = btxm_pkg::ST_CHECK;
                        end
                        btxm_pkg::OP_QUERY: begin
                            if (root_cnt_reg == '0) begin
                                status_next = btxm_pkg::STS_EMPTY;
                                state_next  = btxm_pkg::ST_DONE;
                            end else begin
                                state_next = btxm_pkg::ST_QUERY;
                            end
                        end
                        default: begin
                            state_next = btxm_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            btxm_pkg::ST_CHECK: begin
                if (a_cs == '0 || lvl_reg == '0) begin
                    // path ends here: refuse or restart from the root to update
                    lvl_next    = LVL_TOP;
                    ksh_next    = key_reg;
                    node_a_next = '0;
                    state_next  = btxm_pkg::ST_UPDATE;
                    if (is_ins) begin
                        if (a_cs == '0 && overflow) begin
                            status_next = btxm_pkg::STS_FULL;
                            state_next  = btxm_pkg::ST_DONE;
                        end
                    end else if (a_cs == '0 || a_ns == '0) begin
                        status_next = btxm_pkg::STS_NOT_FOUND;
                        state_next  = btxm_pkg::ST_DONE;
                    end
                end else begin
                    node_a_next = a_cs;
                    lvl_next    = lvl_reg - LVL_W'(1);
                    ksh_next    = ksh_reg << 1;
                end
            end

            btxm_pkg::ST_UPDATE: begin
                mem_we = 1'b1;
                if (lvl_reg == LVL_TOP) begin
                    root_cnt_next = is_ins ? root_cnt_reg + CNT_W'(1)
                                           : root_cnt_reg - CNT_W'(1);
                end
                if (alloc) begin
                    free_next  = free_reg + FREE_W'(1);
                    fresh_next = 1'b1;
                end
                if (lvl_reg == '0) begin
                    fresh_next = 1'b0;
                    state_next = btxm_pkg::ST_DONE;
                end else begin
                    node_a_next = upd_child;
                    lvl_next    = lvl_reg - LVL_W'(1);
                    ksh_next    = ksh_reg << 1;
                end
            end

            btxm_pkg::ST_QUERY: begin
                res_a_next  = {res_a_reg[KEY_BITS-2:0], ba ^ kbit};
                res_b_next  = {res_b_reg[KEY_BITS-2:0], bb ^ kbit};
                node_a_next = nxt_a;
                node_b_next = nxt_b;
                if (lvl_reg == '0) begin
                    state_next = btxm_pkg::ST_DONE;
                end else begin
                    lvl_next = lvl_reg - LVL_W'(1);
                    ksh_next = ksh_reg << 1;
                end
            end

            btxm_pkg::ST_DONE: begin
                done_valid = 1'b1;
                if (done_ready) begin
                    state_next = btxm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = btxm_pkg::ST_IDLE;
            end
        endcase
    end

    assign root_init_next = root_init_reg || (mem_we && mem_waddr == '0);

    assign mem_waddr = node_a_reg;
    assign mem_wdata = {upd_n1, upd_n0, upd_c1, upd_c0};
    assign rd_addr_a = node_a_next;
    assign rd_addr_b = node_b_next;

    assign min_ext          = 64'(res_a_reg);
    assign max_ext          = 64'(res_b_reg);
    assign done_res.status  = status_reg;
    assign done_res.min_xor = min_ext[btxm_pkg::OUT_W-1:0];
    assign done_res.max_xor = max_ext[btxm_pkg::OUT_W-1:0];

    a_we_only_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == btxm_pkg::ST_UPDATE)
        else $error("node write outside an update walk");

    a_free_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> free_reg >= $past(free_reg))
        else $error("node allocator moved backwards");

    a_root_cnt_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && root_cnt_reg != $past(root_cnt_reg))
            |-> $past(state_reg) == btxm_pkg::ST_UPDATE)
        else $error("root count changed outside an update walk");

    a_fresh_only_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg |-> (op_reg == btxm_pkg::OP_INSERT && state_reg == btxm_pkg::ST_UPDATE))
        else $error("fresh node flag outside an insert");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_valid && done_ready) |=> state_reg == btxm_pkg::ST_IDLE)
        else $error("result handed over but sequencer not idle");

endmodule

// File: design/binary_trie_xor_min_max.sv
// Top level: binary trie with min/max xor query, node RAMs and output register.
//
//  channel | dir | tdata (low bit up)                    | tuser
//  s_      | in  | value[30:0], zero pad                  | operation[1:0]
//  m_      | out | min_xor[30:0], max_xor[30:0], zero pad | status[1:0]
//
// One item at a time. Query: both xor walks share the level steps, one node read
// per level from each RAM copy. Insert and delete: a check walk, then a count/link
// update walk, one node read per level. Empty-trie queries, inserts at a full root
// count and the spare code go straight to the result; a missing path on delete or a
// short pool on insert found on the check walk ends the item at that level.
// Reset acts at once: the root carries a written flag, new nodes read as empty on
// allocation, so the RAMs need no clearing pass. A finished word waits in the
// output register while the next input word is taken.
module binary_trie_xor_min_max #(
    parameter int KEY_BITS  = 31,
    parameter int NODE_POOL = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[30:0], pad[31]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // min_xor[30:0], max_xor[61:31], pad[63:62]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int NODE_W = $clog2(NODE_POOL);
    localparam int WORD_W = 2 * NODE_W + 2 * btxm_pkg::CNT_W;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [NODE_W-1:0] rd_addr_a, rd_addr_b;
    logic [WORD_W-1:0] rd_data_a, rd_data_b;
    logic              done_valid, done_ready;
    btxm_pkg::res_t    done_res;

    logic              out_valid_reg, out_valid_next;
    btxm_pkg::res_t    out_res_reg, out_res_next;

    btxm_seq #(
        .KEY_BITS  (KEY_BITS),
        .NODE_POOL (NODE_POOL)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_value   (s_tdata[btxm_pkg::VAL_W-1:0]),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_res   (done_res)
    );

    // Two copies of the node store, written together, one per query walker.
    btxm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_POOL)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr_a),
        .rdata (rd_data_a)
    );

    btxm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_POOL)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr_b),
        .rdata (rd_data_b)
    );

    // Output word register: load when empty or being drained.
    assign done_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (done_valid && done_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = done_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {2'b00, out_res_reg.max_xor, out_res_reg.min_xor};

endmodule

// File: verif/btxm_checker.sv
// Checker for the binary trie min/max xor block: mirrors the trie, predicts and compares.
module btxm_checker
    import btxm_pkg::*;
#(
    parameter int KEY_BITS  = 31,
    parameter int NODE_POOL = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // value[30:0], pad[31]
    input  logic [1:0]  s_tuser,    // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // min_xor[30:0], max_xor[61:31], pad[63:62]
    input  logic [1:0]  m_tuser,    // status[1:0]
    output int          fail_count,
    output int          pending,
    output int          ok_seen,
    output int          empty_seen,
    output int          full_seen,
    output int          absent_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] key;
        res_t             res;
    } answer_t;

    // Local copy of the trie
    int unsigned      zero_kid [NODE_POOL];
    int unsigned      one_kid  [NODE_POOL];
    logic [CNT_W-1:0] passes   [NODE_POOL];
    int unsigned      bump;

    answer_t due_answers [$];
    int      misses;
    int      words_out;
    int      n_ok, n_empty, n_full, n_absent;

    function automatic int unsigned child(int unsigned node, logic b);
        return b ? one_kid[node] : zero_kid[node];
    endfunction

    task automatic clear_trie();
        for (int i = 0; i < NODE_POOL; i++) begin
            zero_kid[i] = 0;
            one_kid[i]  = 0;
            passes[i]   = '0;
        end
        bump = 1;
    endtask

    function automatic logic [ST_W-1:0] trie_insert(logic [KEY_BITS-1:0] key);
        int unsigned node, c, grow;
        int          lv;
        if (passes[0] >= COUNT_MAX)
            return STS_FULL;
        node = 0;
        grow = 0;
        // count the nodes this key still lacks
        for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
            c = child(node, key[lv]);
            if (c == 0) begin
                grow = lv + 1;
                break;
            end
            node = c;
        end
        if (grow > NODE_POOL - bump)
            return STS_FULL;
        node = 0;
        for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
            passes[node] = passes[node] + 1'b1;
            c = child(node, key[lv]);
            if (c == 0) begin
                c = bump;
                bump++;
                if (key[lv])
                    one_kid[node] = c;
                else
                    zero_kid[node] = c;
            end
            node = c;
        end
        passes[node] = passes[node] + 1'b1;
        return STS_OK;
    endfunction

    function automatic logic [ST_W-1:0] trie_delete(logic [KEY_BITS-1:0] key);
        int unsigned node, c;
        int          lv;
        node = 0;
        for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
            c = child(node, key[lv]);
            if (c == 0)
                return STS_NOT_FOUND;
            node = c;
        end
        if (passes[node] == 0)
            return STS_NOT_FOUND;
        node = 0;
        for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
            passes[node] = passes[node] - 1'b1;
            node = child(node, key[lv]);
        end
        passes[node] = passes[node] - 1'b1;
        return STS_OK;
    endfunction

    // far = 0 gives the smallest xor, far = 1 the largest
    function automatic logic [KEY_BITS-1:0] trie_walk(logic [KEY_BITS-1:0] key, logic far);
        int unsigned         node, c;
        int                  lv;
        logic                b;
        logic [KEY_BITS-1:0] path;
        node = 0;
        path = '0;
        for (lv = KEY_BITS - 1; lv >= 0; lv--) begin
            b = key[lv] ^ far;
            c = child(node, b);
            // fall back to the other branch when the preferred one is empty
            if (c == 0 || passes[c] == 0)
                b = ~b;
            path[lv] = b;
            node = child(node, b);
        end
        return path ^ key;
    endfunction

    function automatic res_t predict(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key);
        res_t r;
        r = '0;
        case (op)
            OP_INSERT: r.status = trie_insert(key);
            OP_DELETE: r.status = trie_delete(key);
            OP_QUERY: begin
                if (passes[0] == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.min_xor = trie_walk(key, 1'b0);
                    r.max_xor = trie_walk(key, 1'b1);
                end
            end
            default: r.status = STS_OK;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        answer_t due;
        res_t    got;
        if (!aresetn) begin
            clear_trie();
            due_answers.delete();
            misses    = 0;
            words_out = 0;
            n_ok      = 0;
            n_empty   = 0;
            n_full    = 0;
            n_absent  = 0;
        end else begin
            // retire the oldest word before taking a new one
            if (m_tvalid && m_tready) begin
                got.status  = m_tuser;
                got.min_xor = m_tdata[OUT_W-1:0];
                got.max_xor = m_tdata[2*OUT_W-1:OUT_W];
                case (got.status)
                    STS_OK:    n_ok++;
                    STS_EMPTY: n_empty++;
                    STS_FULL:  n_full++;
                    default:   n_absent++;
                endcase
                if (due_answers.size() == 0) begin
                    misses++;
                    if (misses <= 10)
                        $display("%0t: result word %0d arrived with nothing due %s",
                                 $realtime, words_out,
                                 $sformatf("(status %0d min %h max %h)",
                                           got.status, got.min_xor, got.max_xor));
                end else begin
                    due = due_answers.pop_front();
                    if (got.status != due.res.status || got.min_xor != due.res.min_xor ||
                        got.max_xor != due.res.max_xor) begin
                        misses++;
                        if (misses <= 10) begin
                            $display("%0t: word %0d op %0d key %h", $realtime, words_out,
                                     due.op, due.key);
                            $display("    expected status %0d min %h max %h",
                                     due.res.status, due.res.min_xor, due.res.max_xor);
                            $display("    got      status %0d min %h max %h",
                                     got.status, got.min_xor, got.max_xor);
                        end
                    end
                end
                words_out++;
            end
            if (s_tvalid && s_tready) begin
                due.op  = s_tuser;
                due.key = s_tdata[VAL_W-1:0];
                due.res = predict(s_tuser, s_tdata[KEY_BITS-1:0]);
                due_answers.push_back(due);
            end
        end
        fail_count  <= misses;
        pending     <= due_answers.size();
        ok_seen     <= n_ok;
        empty_seen  <= n_empty;
        full_seen   <= n_full;
        absent_seen <= n_absent;
    end

endmodule

// File: verif/tb_binary_trie_xor_min_max.sv
// Testbench top for the binary trie min/max xor block: clock, reset, stimulus and verdict.
module tb_binary_trie_xor_min_max;
    timeunit 1ns;
    timeprecision 1ps;

    import btxm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int IDLE_PCT    = 70;
    localparam int BOTH_PCT    = 34;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_WORDS = 250;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC,
        PACE_SNK,
        PACE_BOTH
    } pace_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count, pending, ok_seen, empty_seen, full_seen, absent_seen;
    int src_pct    = 0;
    int snk_pct    = 0;
    int hold_asks  = 0;
    int words_sent = 0;

    logic [VAL_W-1:0] stored [$];
    logic [VAL_W-1:0] hub = '0;

    binary_trie_xor_min_max dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    btxm_checker watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending),
        .ok_seen     (ok_seen),
        .empty_seen  (empty_seen),
        .full_seen   (full_seen),
        .absent_seen (absent_seen)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin : sink
        int hold_left;
        int holds_done;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (holds_done != hold_asks) begin
            holds_done = hold_asks;
            hold_left  = HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_pct);
        end
    end

    task automatic set_pace(input pace_t p);
        src_pct = (p == PACE_SRC) ? IDLE_PCT : (p == PACE_BOTH) ? BOTH_PCT : 0;
        snk_pct = (p == PACE_SNK) ? IDLE_PCT : (p == PACE_BOTH) ? BOTH_PCT : 0;
    endtask

    // Offer one word and hold it until taken
    task automatic push_word(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v);
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, v};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
    endtask

    // Stop sending until every due result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] pick_key();
        int               r;
        logic [VAL_W-1:0] v;
        r = $urandom_range(99);
        if (r < 30 || stored.size() == 0) begin
            v = VAL_W'($urandom());
        end else if (r < 55) begin
            v = stored[$urandom_range(stored.size() - 1)];
        end else if (r < 80) begin
            // neighbours of the current hub share long prefixes
            v = hub ^ VAL_W'($urandom_range(255));
        end else if (r < 90) begin
            v = '0;
            case ($urandom_range(3))
                0: v = '0;
                1: v = '1;
                2: v[$urandom_range(VAL_W - 1)] = 1'b1;
                default: begin
                    v[$urandom_range(VAL_W - 1)] = 1'b1;
                    v = ~v;
                end
            endcase
        end else begin
            v = stored[$urandom_range(stored.size() - 1)];
            v[$urandom_range(VAL_W - 1)] ^= 1'b1;
        end
        return v;
    endfunction

    task automatic random_word();
        int               r, k;
        logic [VAL_W-1:0] v;
        r = $urandom_range(99);
        if (r < 40) begin
            v = pick_key();
            push_word(OP_INSERT, v);
            if (stored.size() < 256)
                stored.push_back(v);
        end else if (r < 65) begin
            // mostly remove a value that is held, sometimes one that may be absent
            if (stored.size() != 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(stored.size() - 1);
                v = stored[k];
                stored.delete(k);
            end else begin
                v = pick_key();
            end
            push_word(OP_DELETE, v);
        end else if (r < 95) begin
            push_word(OP_QUERY, pick_key());
        end else begin
            push_word(OP_SPARE, pick_key());
        end
    endtask

    initial begin : stim
        int fill;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_pace(PACE_FREE);
        push_word(OP_QUERY, '0);
        push_word(OP_DELETE, 31'd5);
        push_word(OP_SPARE, '0);
        push_word(OP_INSERT, '0);
        push_word(OP_INSERT, '1);
        push_word(OP_QUERY, '0);
        push_word(OP_QUERY, '1);
        push_word(OP_QUERY, 31'h2AAA_AAAA);
        push_word(OP_QUERY, 31'h5555_5555);
        push_word(OP_INSERT, '0);
        push_word(OP_DELETE, '0);
        push_word(OP_QUERY, '0);
        push_word(OP_DELETE, '0);
        // path still there but its count is spent
        push_word(OP_DELETE, '0);
        push_word(OP_DELETE, 31'd1);
        push_word(OP_QUERY, 31'd1);
        push_word(OP_DELETE, '1);
        push_word(OP_QUERY, 31'd12345);
        push_word(OP_INSERT, 31'h4000_0000);
        push_word(OP_INSERT, 31'h3FFF_FFFF);
        push_word(OP_QUERY, 31'h4000_0000);
        push_word(OP_SPARE, '1);
        push_word(OP_DELETE, 31'h4000_0000);
        push_word(OP_DELETE, 31'h3FFF_FFFF);
        push_word(OP_QUERY, 31'h7000_0001);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_pace(pace_t'(ph % 4));
            hub = VAL_W'($urandom());
            // long receiver hold-off while words keep coming
            if (ph == 0 || ph == 4)
                hold_asks++;
            repeat (PHASE_WORDS) random_word();
            drain();
        end

        // exhaust the node pool with fresh keys
        set_pace(PACE_FREE);
        fill = 0;
        while (full_seen == 0 && fill < 8000) begin
            push_word(OP_INSERT, VAL_W'($urandom()));
            fill++;
        end
        set_pace(PACE_BOTH);
        repeat (200) random_word();

        drain();
        repeat (200) @(posedge aclk);
        $display("Run covered %0d words: %0d ok, %0d empty-trie queries,",
                 words_sent, ok_seen, empty_seen);
        $display("  %0d pool-full refusals, %0d absent deletes.", full_seen, absent_seen);
        $display("Directed corners, mixed random traffic under four pacing modes, %s",
                 $sformatf("then %0d fill inserts.", fill));
        if (fail_count == 0)
            $display("binary_trie_xor_min_max: match");
        else
            $display("binary_trie_xor_min_max: mismatch");
        $finish;
    end

    initial begin
        #50ms;
        $display("Timed out with %0d results still due", pending);
        $display("binary_trie_xor_min_max: mismatch");
        $finish;
    end

endmodule

// File: sim.f
design/btxm_pkg.sv
design/btxm_ram.sv
design/btxm_seq.sv
design/binary_trie_xor_min_max.sv
verif/btxm_checker.sv
verif/tb_binary_trie_xor_min_max.sv
